// File: rtl/core/drab_pkg.sv
// drab_pkg: shared types, widths and register codes for the detection row
// argmax and box decode block. No dependencies.
package drab_pkg;

    localparam int unsigned MAX_CLASSES = 128;
    localparam int unsigned ELEM_W      = 18;
    localparam int unsigned LABEL_W     = 7;
    localparam int unsigned POS_W       = 8;
    localparam int unsigned CORNER_W    = 20;   // 2*centre +/- extent
    localparam int unsigned PROD_W      = 34;   // corner times frame size
    localparam int unsigned PIX_W       = 17;   // whole pixels before clamp
    localparam int unsigned FRAC_BITS   = 17;   // corners are Q.17
    localparam int unsigned RECT_POS_W  = 15;
    localparam int unsigned RECT_LEN_W  = 14;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLASS_COUNT  = 8'd0,
        CFG_FRAME_WIDTH  = 8'd1,
        CFG_FRAME_HEIGHT = 8'd2,
        CFG_SCORE_THRESH = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  class_count;
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [15:0] score_threshold;
    } t_cfg;

    // One finished row that passed the threshold, waiting for box decode.
    typedef struct packed {
        logic [LABEL_W-1:0]         label;
        logic signed [ELEM_W-1:0]   score;
        logic signed [CORNER_W-1:0] x0;
        logic signed [CORNER_W-1:0] x1;
        logic signed [CORNER_W-1:0] y0;
        logic signed [CORNER_W-1:0] y1;
    } t_job;

    // Queue status toward the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

// File: rtl/core/drab_if.sv
// drab_if: valid/ready channel interfaces for elements, detections and
// configuration writes. Depends on drab_pkg.
interface drab_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [drab_pkg::ELEM_W-1:0]     element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface drab_out_if;
    logic                                       valid;
    logic                                       ready;
    logic [drab_pkg::LABEL_W-1:0]               class_label;
    logic signed [drab_pkg::ELEM_W-1:0]         best_score;
    logic signed [drab_pkg::RECT_POS_W-1:0]     rect_x;
    logic signed [drab_pkg::RECT_POS_W-1:0]     rect_y;
    logic [drab_pkg::RECT_LEN_W-1:0]            rect_width;
    logic [drab_pkg::RECT_LEN_W-1:0]            rect_height;

    modport source (output valid, output class_label, output best_score, output rect_x,
                    output rect_y, output rect_width, output rect_height, input ready);
    modport sink   (input valid, input class_label, input best_score, input rect_x,
                    input rect_y, input rect_width, input rect_height, output ready);
endinterface

interface drab_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [drab_pkg::CFG_IDX_W-1:0]     index;
    logic [drab_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/detection_row_argmax_box_decode.sv
// detection_row_argmax_box_decode: top level; configuration registers plus
// front, job queue and back. Depends on drab_pkg, drab_if and all drab_* modules.
//
// Usage:
//   i_elem streams detector tensor elements, one item per cycle. Each row is
//   four box values (cx, cy, w, h, Q2.16) then class_count class scores.
//   o_det carries one detection at the end of a row whose best score is at
//   least score_threshold: label, score and a clamped pixel rectangle.
//   i_cfg writes the four registers (index 0..3); writes to other indexes are
//   ignored. ready is always high; write only while no row result is pending.
// Throughput: one element per cycle, sustained. The front takes an element
//   every cycle unless the 4-entry job queue is full.
// Result path: a row's job is queued when its last element is taken, then
//   passes the scale multiply, truncate and clamp registers to o_det.
// Stall: while o_det is stalled the back holds its pipeline; queued jobs keep
//   arriving until the queue fills, then i_elem.ready drops.
// Reset: row position restarts, queue and pipeline empty, registers return
//   to 80 classes, 640x640 frame, threshold 29491 (0.45).
module detection_row_argmax_box_decode (
    input  logic        i_clk,
    input  logic        i_rst_n,
    drab_in_if.sink     i_elem,
    drab_cfg_if.sink    i_cfg,
    drab_out_if.source  o_det
);

    drab_pkg::t_cfg         r_cfg;
    drab_pkg::t_queue_stat  qstat;
    drab_pkg::t_job         push_job;
    drab_pkg::t_job         head_job;
    logic                   push;
    logic                   pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.class_count     <= 8'd80;
            r_cfg.frame_width     <= 13'd640;
            r_cfg.frame_height    <= 13'd640;
            r_cfg.score_threshold <= 16'd29491;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                drab_pkg::CFG_CLASS_COUNT:  r_cfg.class_count     <= i_cfg.data[7:0];
                drab_pkg::CFG_FRAME_WIDTH:  r_cfg.frame_width     <= i_cfg.data[12:0];
                drab_pkg::CFG_FRAME_HEIGHT: r_cfg.frame_height    <= i_cfg.data[12:0];
                drab_pkg::CFG_SCORE_THRESH: r_cfg.score_threshold <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Front: row counting, box capture, argmax, threshold.
    drab_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_qstat (qstat),
        .i_elem  (i_elem),
        .o_push  (push),
        .o_job   (push_job)
    );

    // Decouples the element stream from output stalls.
    drab_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (qstat)
    );

    // Back: box to pixel rectangle and output register.
    drab_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_qstat (qstat),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_det   (o_det)
    );

endmodule

// File: rtl/core/drab_front.sv
// drab_front: row position counter, box capture and running argmax; pushes
// a job for every row whose best score passes. Depends on drab_pkg, drab_if.
module drab_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  drab_pkg::t_cfg          i_cfg,
    input  drab_pkg::t_queue_stat   i_qstat,
    drab_in_if.sink                 i_elem,
    output logic                    o_push,
    output drab_pkg::t_job          o_job
);

    logic [drab_pkg::POS_W-1:0]             r_pos, n_pos;
    logic signed [drab_pkg::ELEM_W-1:0]     r_box [4];
    logic signed [drab_pkg::ELEM_W-1:0]     r_best, n_best;
    logic [drab_pkg::LABEL_W-1:0]           r_idx, n_idx;
    logic [drab_pkg::POS_W-1:0]             cc_eff;
    logic [drab_pkg::POS_W-1:0]             last_pos;
    logic [drab_pkg::POS_W-1:0]             cls_pos;
    logic                                   accept;
    logic                                   row_end;
    logic                                   pass;
    logic signed [drab_pkg::ELEM_W-1:0]     v;

    assign v        = i_elem.element_value;
    assign i_elem.ready = !i_qstat.full;
    assign accept   = i_elem.valid && i_elem.ready;

    always_comb begin
        if (i_cfg.class_count == '0) begin
            cc_eff = drab_pkg::POS_W'(1);
        end else if (i_cfg.class_count > drab_pkg::POS_W'(drab_pkg::MAX_CLASSES)) begin
            cc_eff = drab_pkg::POS_W'(drab_pkg::MAX_CLASSES);
        end else begin
            cc_eff = i_cfg.class_count;
        end
    end

    assign last_pos = cc_eff + drab_pkg::POS_W'(3);
    assign cls_pos  = r_pos - drab_pkg::POS_W'(4);
    assign row_end  = (r_pos >= last_pos);

    // Running argmax: first class score always loads, ties keep the earlier one.
    always_comb begin
        n_best = r_best;
        n_idx  = r_idx;
        if (r_pos >= drab_pkg::POS_W'(4)) begin
            if (r_pos == drab_pkg::POS_W'(4) || v > r_best) begin
                n_best = v;
                n_idx  = cls_pos[drab_pkg::LABEL_W-1:0];
            end
        end
    end

    assign n_pos = row_end ? '0 : r_pos + drab_pkg::POS_W'(1);

    // Signed score against unsigned threshold: negatives never pass.
    assign pass = !n_best[drab_pkg::ELEM_W-1] &&
                  (n_best[drab_pkg::ELEM_W-2:0] >= {1'b0, i_cfg.score_threshold});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_best <= '0;
            r_idx  <= '0;
        end else if (accept) begin
            r_pos  <= n_pos;
            r_best <= n_best;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_pos < drab_pkg::POS_W'(4)) begin
            r_box[r_pos[1:0]] <= v;
        end
    end

    // Corners in Q.17: 2*centre -/+ extent.
    always_comb begin
        o_job.label = n_idx;
        o_job.score = n_best;
        o_job.x0 = (drab_pkg::CORNER_W'(r_box[0]) <<< 1) - drab_pkg::CORNER_W'(r_box[2]);
        o_job.x1 = (drab_pkg::CORNER_W'(r_box[0]) <<< 1) + drab_pkg::CORNER_W'(r_box[2]);
        o_job.y0 = (drab_pkg::CORNER_W'(r_box[1]) <<< 1) - drab_pkg::CORNER_W'(r_box[3]);
        o_job.y1 = (drab_pkg::CORNER_W'(r_box[1]) <<< 1) + drab_pkg::CORNER_W'(r_box[3]);
    end

    assign o_push = accept && row_end && pass;

endmodule

// File: rtl/core/drab_queue.sv
// drab_queue: small job FIFO between front and back parts.
// Depends on drab_pkg.
module drab_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  drab_pkg::t_job          i_job,
    input  logic                    i_pop,
    output drab_pkg::t_job          o_job,
    output drab_pkg::t_queue_stat   o_stat
);

    drab_pkg::t_job                 r_mem [drab_pkg::QUEUE_DEPTH];
    logic [drab_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [drab_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [drab_pkg::QPTR_W:0]      r_count, n_count;

    assign o_stat.full  = (r_count == (drab_pkg::QPTR_W+1)'(drab_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_job        = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: rtl/core/drab_back.sv
// drab_back: three-stage box decode (scale, truncate, then min/extent/clamp into
// the output register). Depends on drab_pkg, drab_if.
module drab_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  drab_pkg::t_cfg          i_cfg,
    input  drab_pkg::t_queue_stat   i_qstat,
    input  drab_pkg::t_job          i_job,
    output logic                    o_pop,
    drab_out_if.source              o_det
);

    localparam int unsigned PW = drab_pkg::PROD_W;
    localparam int unsigned XW = drab_pkg::PIX_W;
    localparam int unsigned FB = drab_pkg::FRAC_BITS;

    // stage 1: products
    logic                               r1_v;
    logic [drab_pkg::LABEL_W-1:0]       r1_label;
    logic signed [drab_pkg::ELEM_W-1:0] r1_score;
    logic signed [PW-1:0]               r1_px0, r1_px1, r1_py0, r1_py1;
    // stage 2: whole pixels
    logic                               r2_v;
    logic [drab_pkg::LABEL_W-1:0]       r2_label;
    logic signed [drab_pkg::ELEM_W-1:0] r2_score;
    logic signed [XW-1:0]               r2_x0, r2_x1, r2_y0, r2_y1;
    // stage 3: output register
    logic                               r3_v;

    logic adv1, adv2, adv3;
    logic signed [drab_pkg::RECT_POS_W-1:0] n_rx, n_ry;
    logic [drab_pkg::RECT_LEN_W-1:0]        n_rw, n_rh;

    assign adv3  = r2_v && (!r3_v || o_det.ready);
    assign adv2  = r1_v && (!r2_v || adv3);
    assign adv1  = !i_qstat.empty && (!r1_v || adv2);
    assign o_pop = adv1;
    assign o_det.valid = r3_v;

    function automatic logic signed [PW-1:0] scale_corner(
        input logic signed [drab_pkg::CORNER_W-1:0] corner,
        input logic [12:0]                          size
    );
        logic signed [PW-1:0] c;
        logic signed [PW-1:0] s;
        c = PW'(corner);
        s = $signed(PW'(size));
        return c * s;
    endfunction

    // Divide by 2^17 toward zero: bias negatives before the shift.
    function automatic logic signed [XW-1:0] to_pixel(input logic signed [PW-1:0] p);
        logic [PW-1:0] sum;
        sum = p + (p[PW-1] ? PW'((1 << FB) - 1) : PW'(0));
        return sum[PW-1:FB];
    endfunction

    function automatic logic signed [drab_pkg::RECT_POS_W-1:0] clamp_pos(
        input logic signed [XW-1:0] q
    );
        if (q < -(XW'(1) <<< (drab_pkg::RECT_POS_W-1))) begin
            return {1'b1, {(drab_pkg::RECT_POS_W-1){1'b0}}};
        end else if (q > XW'((1 << (drab_pkg::RECT_POS_W-1)) - 1)) begin
            return {1'b0, {(drab_pkg::RECT_POS_W-1){1'b1}}};
        end else begin
            return q[drab_pkg::RECT_POS_W-1:0];
        end
    endfunction

    function automatic logic [drab_pkg::RECT_LEN_W-1:0] clamp_len(
        input logic [XW:0] d
    );
        if (d > (XW+1)'((1 << drab_pkg::RECT_LEN_W) - 1)) begin
            return '1;
        end else begin
            return d[drab_pkg::RECT_LEN_W-1:0];
        end
    endfunction

    always_comb begin
        logic signed [XW-1:0] xlo, xhi, ylo, yhi;
        logic [XW:0]          xd, yd;
        xlo  = (r2_x0 < r2_x1) ? r2_x0 : r2_x1;
        xhi  = (r2_x0 < r2_x1) ? r2_x1 : r2_x0;
        ylo  = (r2_y0 < r2_y1) ? r2_y0 : r2_y1;
        yhi  = (r2_y0 < r2_y1) ? r2_y1 : r2_y0;
        xd   = (XW+1)'(xhi) - (XW+1)'(xlo);
        yd   = (XW+1)'(yhi) - (XW+1)'(ylo);
        n_rx = clamp_pos(xlo);
        n_ry = clamp_pos(ylo);
        n_rw = clamp_len(xd);
        n_rh = clamp_len(yd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (adv1) begin
                r1_v <= 1'b1;
            end else if (adv2) begin
                r1_v <= 1'b0;
            end
            if (adv2) begin
                r2_v <= 1'b1;
            end else if (adv3) begin
                r2_v <= 1'b0;
            end
            if (adv3) begin
                r3_v <= 1'b1;
            end else if (o_det.ready) begin
                r3_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_label <= i_job.label;
            r1_score <= i_job.score;
            r1_px0   <= scale_corner(i_job.x0, i_cfg.frame_width);
            r1_px1   <= scale_corner(i_job.x1, i_cfg.frame_width);
            r1_py0   <= scale_corner(i_job.y0, i_cfg.frame_height);
            r1_py1   <= scale_corner(i_job.y1, i_cfg.frame_height);
        end
        if (adv2) begin
            r2_label <= r1_label;
            r2_score <= r1_score;
            r2_x0    <= to_pixel(r1_px0);
            r2_x1    <= to_pixel(r1_px1);
            r2_y0    <= to_pixel(r1_py0);
            r2_y1    <= to_pixel(r1_py1);
        end
        if (adv3) begin
            o_det.class_label <= r2_label;
            o_det.best_score  <= r2_score;
            o_det.rect_x      <= n_rx;
            o_det.rect_y      <= n_ry;
            o_det.rect_width  <= n_rw;
            o_det.rect_height <= n_rh;
        end
    end

endmodule

// File: verif/testbench.sv
// testbench: streams detector rows into detection_row_argmax_box_decode and checks every
// detection against an in-bench row decoder (argmax, threshold, box to pixel rectangle).
// Depends on drab_pkg, drab_if and the RTL of the block.
`timescale 1ns / 100ps

module testbench;
    import drab_pkg::*;

    // Random stimulus budget, drain time after the last result, and the run limit.
    // The run limit leaves a wide margin over the slowest legal run.
    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned CYCLE_LIMIT  = 300000;

    // Any index past the last register is ignored by the block.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'hA5;

    localparam longint PIX_DIV  = longint'(1) << FRAC_BITS;
    localparam longint RECT_MIN = -(longint'(1) << (RECT_POS_W - 1));
    localparam longint RECT_MAX = (longint'(1) << (RECT_POS_W - 1)) - 1;
    localparam longint LEN_MAX  = (longint'(1) << RECT_LEN_W) - 1;

    // One detection as it leaves the block.
    typedef struct packed {
        logic [LABEL_W-1:0]           class_label;
        logic signed [ELEM_W-1:0]     best_score;
        logic signed [RECT_POS_W-1:0] rect_x;
        logic signed [RECT_POS_W-1:0] rect_y;
        logic [RECT_LEN_W-1:0]        rect_width;
        logic [RECT_LEN_W-1:0]        rect_height;
    } det_t;

    typedef enum logic [1:0] {
        STEP_ELEM,
        STEP_REG
    } step_kind_t;

    // One directed step: an element, or a register write (data in value[15:0]).
    // pinned marks a row end whose detection is written out by hand.
    typedef struct packed {
        step_kind_t             kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [ELEM_W-1:0]      value;
        logic                   pinned;
        det_t                   result;
    } stim_step_t;

    // How the class scores of one row are drawn.
    typedef enum int unsigned {
        SCORES_WIDE,
        SCORES_NEAR_THRESH,
        SCORES_TIED,
        SCORES_UNIT,
        SCORES_EXTREME,
        SCORES_LOW
    } score_style_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    drab_in_if  elem_if ();
    drab_cfg_if cfg_if ();
    drab_out_if det_if ();

    detection_row_argmax_box_decode dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (elem_if),
        .i_cfg   (cfg_if),
        .o_det   (det_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Row decoder: own copy of the registers and of the row state.
    // Register values here are the reset values of the block.
    // ---------------------------------------------------------------------
    logic [7:0]               reg_classes = 8'd80;
    logic [12:0]              reg_frame_w = 13'd640;
    logic [12:0]              reg_frame_h = 13'd640;
    logic [15:0]              reg_thresh  = 16'd29491;

    int unsigned              row_pos     = 0;
    logic signed [ELEM_W-1:0] box_vals [4] = '{default: '0};
    logic signed [ELEM_W-1:0] best_val    = '0;
    int unsigned              best_idx    = 0;

    det_t        expected_dets [$];    // detections predicted, oldest first
    int unsigned fail_count = 0;
    int unsigned elems_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_pct = 0;         // odds of a gap or stall burst, percent

    // Hand-written detection for the element now on the bus.
    logic        pin_on  = 1'b0;
    det_t        pin_det = '0;

    // Position of the last element of a row. Zero classes act as one,
    // anything past MAX_CLASSES acts as MAX_CLASSES.
    function automatic int unsigned row_last_pos();
        int unsigned cc;
        cc = reg_classes;
        if (cc == 0) cc = 1;
        if (cc > MAX_CLASSES) cc = MAX_CLASSES;
        return cc + 3;
    endfunction

    // One axis: corners are 2*centre -/+ extent in Q.17, scaled to pixels and
    // truncated toward zero. Left edge and extent are saturated.
    function automatic void scale_edge(input longint centre, input longint extent,
                                       input longint scale,
                                       output longint pos, output longint len);
        longint a, b, lo, hi;
        a  = ((2 * centre - extent) * scale) / PIX_DIV;
        b  = ((2 * centre + extent) * scale) / PIX_DIV;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        pos = (lo < RECT_MIN) ? RECT_MIN : ((lo > RECT_MAX) ? RECT_MAX : lo);
        len = hi - lo;
        if (len > LEN_MAX) len = LEN_MAX;
    endfunction

    // Consume one element; returns 1 with the detection when a row closes
    // at or above threshold.
    function automatic bit decode_row_element(input logic signed [ELEM_W-1:0] v,
                                              output det_t d);
        int unsigned p;
        longint px, py, pw, ph;
        p = row_pos;
        d = '0;
        if (p < 4) begin
            box_vals[p] = v;
        end else if (p == 4 || v > best_val) begin
            // first score of the row always loads; ties keep the earlier index
            best_val = v;
            best_idx = p - 4;
        end
        // a shrunk class count can leave us past the new row end: close now
        if (p < row_last_pos()) begin
            row_pos = p + 1;
            return 1'b0;
        end
        row_pos = 0;
        // signed score against unsigned threshold, so negatives never pass
        if (longint'(best_val) < longint'(reg_thresh)) return 1'b0;
        scale_edge(box_vals[0], box_vals[2], reg_frame_w, px, pw);
        scale_edge(box_vals[1], box_vals[3], reg_frame_h, py, ph);
        d.class_label = best_idx[LABEL_W-1:0];
        d.best_score  = best_val;
        d.rect_x      = px[RECT_POS_W-1:0];
        d.rect_y      = py[RECT_POS_W-1:0];
        d.rect_width  = pw[RECT_LEN_W-1:0];
        d.rect_height = ph[RECT_LEN_W-1:0];
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // ---------------------------------------------------------------------
    // Checker: everything sampled at the rising edge.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : det_checker
        det_t calc;
        det_t seen;
        bit   fires;
        if (i_rst_n) begin
            if (det_if.valid && det_if.ready) begin
                seen.class_label = det_if.class_label;
                seen.best_score  = det_if.best_score;
                seen.rect_x      = det_if.rect_x;
                seen.rect_y      = det_if.rect_y;
                seen.rect_width  = det_if.rect_width;
                seen.rect_height = det_if.rect_height;
                if (expected_dets.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected detection, expected none, got label %0d score %0d",
                             $time, seen.class_label, seen.best_score);
                end else begin
                    calc = expected_dets.pop_front();
                    check_field("class_label", calc.class_label, seen.class_label);
                    check_field("best_score", calc.best_score, seen.best_score);
                    check_field("rect_x", calc.rect_x, seen.rect_x);
                    check_field("rect_y", calc.rect_y, seen.rect_y);
                    check_field("rect_width", calc.rect_width, seen.rect_width);
                    check_field("rect_height", calc.rect_height, seen.rect_height);
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    CFG_CLASS_COUNT:  reg_classes = cfg_if.data[7:0];
                    CFG_FRAME_WIDTH:  reg_frame_w = cfg_if.data[12:0];
                    CFG_FRAME_HEIGHT: reg_frame_h = cfg_if.data[12:0];
                    CFG_SCORE_THRESH: reg_thresh  = cfg_if.data[15:0];
                    default: ;
                endcase
            end
            if (elem_if.valid && elem_if.ready) begin
                fires = decode_row_element(elem_if.element_value, calc);
                if (pin_on)
                    expected_dets.insert(expected_dets.size(), pin_det);
                else if (fires)
                    expected_dets.insert(expected_dets.size(), calc);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d detections outstanding", $time, expected_dets.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: ready drops in random bursts while idle_pct is nonzero.
    initial begin : det_stall
        int unsigned hold;
        hold = 0;
        det_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold != 0) begin
                hold--;
                det_if.ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                hold = $urandom_range(1, 14) - 1;
                det_if.ready <= 1'b0;
            end else begin
                det_if.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Element and register drivers. Everything changes at the falling edge.
    // ---------------------------------------------------------------------
    task automatic push_element(input logic [ELEM_W-1:0] v, input logic pinned,
                                input det_t fixed);
        int unsigned gap;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 14);
        @(negedge i_clk);
        if (gap != 0) begin
            elem_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pin_on  = pinned;
        pin_det = fixed;
        elem_if.valid         <= 1'b1;
        elem_if.element_value <= v;
        do @(posedge i_clk); while (!elem_if.ready);
        elems_sent++;
    endtask

    // Stop sending, let every predicted detection come out, then give the
    // block time to finish rows that close without a result.
    task automatic wait_block_idle();
        @(negedge i_clk);
        elem_if.valid <= 1'b0;
        while (expected_dets.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_block_idle();
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Register value pickers; unused upper data bits are random.
    function automatic logic [CFG_DATA_W-1:0] pick_class_count();
        int unsigned r, n;
        r = $urandom_range(0, 19);
        if (r == 0)      n = 0;
        else if (r == 1) n = MAX_CLASSES;
        else if (r == 2) n = $urandom_range(MAX_CLASSES + 1, 255);
        else if (r == 3) n = $urandom_range(21, MAX_CLASSES - 1);
        else if (r < 10) n = $urandom_range(7, 20);
        else             n = $urandom_range(1, 6);
        return {8'($urandom), 8'(n)};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_frame_size();
        int unsigned r, n;
        r = $urandom_range(0, 9);
        case (r)
            0:       n = 0;
            1:       n = 1;
            2:       n = 4096;
            3:       n = 8191;
            4:       n = 640;
            5:       n = $urandom_range(4097, 8191);
            default: n = $urandom_range(1, 4096);
        endcase
        return {3'($urandom), 13'(n)};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return 16'hFFFF;
        if (r == 2) return 16'($urandom);
        return 16'($urandom_range(0, 8192));
    endfunction

    task automatic random_setup();
        if ($urandom_range(0, 9) < 6) write_reg(CFG_CLASS_COUNT, pick_class_count());
        if ($urandom_range(0, 9) < 6) write_reg(CFG_FRAME_WIDTH, pick_frame_size());
        if ($urandom_range(0, 9) < 6) write_reg(CFG_FRAME_HEIGHT, pick_frame_size());
        if ($urandom_range(0, 9) < 6) write_reg(CFG_SCORE_THRESH, pick_threshold());
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_IDX_W'($urandom_range(int'(CFG_SCORE_THRESH) + 1, 255)),
                      CFG_DATA_W'($urandom));
    endtask

    // Row positions span_lo..span_hi: box values first, then class scores.
    task automatic stream_row_span(input int unsigned span_lo, input int unsigned span_hi);
        int unsigned       p;
        int                near;
        bit                unit_box;
        score_style_t      style;
        logic [ELEM_W-1:0] tie_val, v;
        unit_box = $urandom_range(0, 1);
        style    = score_style_t'($urandom_range(0, 5));
        tie_val  = ELEM_W'($urandom);
        for (p = span_lo; p <= span_hi; p++) begin
            if (p < 4) begin
                v = unit_box ? ELEM_W'($urandom_range(0, 65536)) : ELEM_W'($urandom);
            end else begin
                case (style)
                    SCORES_NEAR_THRESH: begin
                        near = int'(reg_thresh) + int'($urandom_range(0, 8)) - 4;
                        v = ELEM_W'(near);
                    end
                    SCORES_TIED:    v = tie_val;
                    SCORES_UNIT:    v = ELEM_W'($urandom_range(0, 65535));
                    SCORES_EXTREME: begin
                        case ($urandom_range(0, 2))
                            0:       v = 18'h1FFFF;
                            1:       v = 18'h20000;
                            default: v = '0;
                        endcase
                    end
                    SCORES_LOW:     v = ELEM_W'($urandom_range(0, 100));
                    default:        v = ELEM_W'($urandom);
                endcase
            end
            push_element(v, 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------------
    // Directed steps. Box values are Q2.16: 18'h10000 is 1.0, 18'h08000 is
    // 0.5, 18'h1FFFF / 18'h20000 are the field extremes.
    // ---------------------------------------------------------------------
    stim_step_t directed_steps [] = '{
        // one class; upper data bits of the write must be dropped
        '{STEP_REG,  CFG_CLASS_COUNT,  18'h0FF01, 1'b0, '0},
        // centred full-frame box at the reset 640x640 frame and 0.45 threshold
        '{STEP_ELEM, '0, 18'h08000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h08000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h10000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h10000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h10000, 1'b1,
          '{7'd0, 18'sd65536, 15'sd0, 15'sd0, 14'd640, 14'd640}},
        // most negative score: never passes
        '{STEP_ELEM, '0, 18'h1FFFF, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h20000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h00000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h00001, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h20000, 1'b0, '0},
        // score exactly at the top threshold passes; empty box
        '{STEP_REG,  CFG_SCORE_THRESH, 18'h0FFFF, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h00000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h00000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h00000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h00000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h0FFFF, 1'b1,
          '{7'd0, 18'sd65535, 15'sd0, 15'sd0, 14'd0, 14'd0}},
        // widest frame (data masked to 13 bits), extreme box: left edge saturates
        '{STEP_REG,  CFG_SCORE_THRESH, 18'h00000, 1'b0, '0},
        '{STEP_REG,  CFG_FRAME_WIDTH,  18'h0FFFF, 1'b0, '0},
        '{STEP_REG,  CFG_FRAME_HEIGHT, 18'h01FFF, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h20000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h1FFFF, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h1FFFF, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h20000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h1FFFF, 1'b0, '0},
        // zero frame width flattens x; zero class count runs as one class
        '{STEP_REG,  CFG_FRAME_WIDTH,  18'h00000, 1'b0, '0},
        '{STEP_REG,  CFG_CLASS_COUNT,  18'h00000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h10000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h10000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h10000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h10000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h00000, 1'b0, '0},
        // three classes, tie on the top score keeps the first index
        '{STEP_REG,  CFG_FRAME_WIDTH,  18'h00280, 1'b0, '0},
        '{STEP_REG,  CFG_FRAME_HEIGHT, 18'h00280, 1'b0, '0},
        '{STEP_REG,  CFG_CLASS_COUNT,  18'h00003, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h04000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h04000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h08000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h08000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'd100,   1'b0, '0},
        '{STEP_ELEM, '0, 18'd200,   1'b0, '0},
        '{STEP_ELEM, '0, 18'd200,   1'b1,
          '{7'd1, 18'sd200, 15'sd0, 15'sd0, 14'd320, 14'd320}},
        // class count shrinks mid-row: the next element is a score and closes the row
        '{STEP_REG,  CFG_CLASS_COUNT,  18'h00005, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h08000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h08000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h10000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'h10000, 1'b0, '0},
        '{STEP_ELEM, '0, 18'd10,    1'b0, '0},
        '{STEP_ELEM, '0, 18'd20,    1'b0, '0},
        '{STEP_ELEM, '0, 18'd5,     1'b0, '0},
        '{STEP_REG,  CFG_CLASS_COUNT,  18'h00002, 1'b0, '0},
        '{STEP_ELEM, '0, 18'd30,    1'b1,
          '{7'd3, 18'sd30, 15'sd0, 15'sd0, 14'd640, 14'd640}},
        // write to an unmapped index changes nothing
        '{STEP_REG,  CFG_IDX_SPARE,    18'h0FFFF, 1'b0, '0}
    };

    initial begin : stimulus
        int unsigned random_base, rows, cut, p;
        elem_if.valid         = 1'b0;
        elem_if.element_value = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = '0;
        cfg_if.data           = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 15;
        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_REG)
                write_reg(directed_steps[i].reg_idx, directed_steps[i].value[CFG_DATA_W-1:0]);
            else
                push_element(directed_steps[i].value, directed_steps[i].pinned,
                             directed_steps[i].result);
        end

        // Random phases: new register setting (taken with the block drained,
        // which also holds the sender until every detection is out), then rows.
        random_base = elems_sent;
        while (elems_sent - random_base < RANDOM_ITEMS) begin
            if (elems_sent - random_base > RANDOM_ITEMS * 4 / 5) begin
                idle_pct = 0;               // closing stretch runs flat out
            end else begin
                case ($urandom_range(0, 3))
                    0:       idle_pct = 0;
                    1:       idle_pct = 3;
                    2:       idle_pct = 10;
                    default: idle_pct = 30;
                endcase
            end
            random_setup();
            rows = (row_last_pos() > 40) ? 1 : $urandom_range(2, 10);
            repeat (rows) stream_row_span(0, row_last_pos());
            if ($urandom_range(0, 5) == 0) begin
                // stop inside a row, change the class count, finish the row
                cut = $urandom_range(0, row_last_pos() - 1);
                stream_row_span(0, cut);
                write_reg(CFG_CLASS_COUNT, pick_class_count());
                p = row_pos;                // stable: block is drained here
                if (p > row_last_pos())
                    stream_row_span(p, p);
                else
                    stream_row_span(p, row_last_pos());
            end
        end

        idle_pct = 0;
        wait_block_idle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
